// File: rtl/core/rgbhsl_pkg.sv
package rgbhsl_pkg;

	localparam int CH_W   = 8;   // width of one color channel
	localparam int SUM_W  = 9;   // max + min, 0..510
	localparam int FRAC_W = 16;  // Q0.16 hue and saturation
	localparam int HDIV_W = 11;  // 6 * (max - min), up to 1530
	localparam int DIFF_W = 9;   // signed difference of two channels

	localparam logic [FRAC_W-1:0] SAT_MAX = {FRAC_W{1'b1}};

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [FRAC_W-1:0] hue;
		logic [FRAC_W-1:0] saturation;
		logic [SUM_W-1:0]  lightness_sum;
		logic              achromatic;
	} hsl_t;

	// Which channel holds the maximum.
	typedef enum logic [1:0] {
		SEL_RED   = 2'b00,
		SEL_GREEN = 2'b01,
		SEL_BLUE  = 2'b10
	} max_sel_t;

	// Extremes and the hue offset difference after the first stage.
	typedef struct packed {
		logic [CH_W-1:0]          hi;
		logic [CH_W-1:0]          lo;
		logic signed [DIFF_W-1:0] diff;
		max_sel_t                 sel;
	} ext_t;

	// One slot of the divider pipeline: two restoring divisions side by side.
	typedef struct packed {
		logic [HDIV_W-1:0] hrem;
		logic [HDIV_W-1:0] hdiv;
		logic [FRAC_W-1:0] hquo;
		logic [CH_W-1:0]   srem;
		logic [CH_W-1:0]   sdiv;
		logic [FRAC_W-1:0] squo;
		logic              sat_full;
		logic              achro;
		logic [SUM_W-1:0]  lsum;
	} div_slot_t;

endpackage

// File: rtl/core/rgb_to_hsl_converter_unit.sv
// RGB to HSL converter. Takes one 8-bit RGB pixel per clock on the pixel
// channel and returns hue and saturation in Q0.16 (floored), the lightness as
// the exact sum max + min (lightness = lightness_sum / 510), and an achromatic
// flag that is set, with hue and saturation forced to zero, when all channels
// are equal. Red wins ties for the maximum, then green. Throughput is one
// pixel per clock while the output is not stalled. The pipe holds one
// stage for max/min, one for the divisor and dividend setup, sixteen
// restoring-division stages that each resolve one quotient bit of both
// hue and saturation, and the output register. A stall on the hsl
// channel freezes the whole pipe, so pixel_ready drops only while a finished
// result waits and hsl_ready is low.
module rgb_to_hsl_converter_unit
	import rgbhsl_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pixel_valid,
	output logic   pixel_ready,
	input  pixel_t pixel,
	output logic   hsl_valid,
	input  logic   hsl_ready,
	output hsl_t   hsl
);

	// One restoring step: double the remainder, subtract the divisor if it fits,
	// shift the resulting bit into the quotient. Remainder stays below divisor.
	function automatic div_slot_t div_step(input div_slot_t a);
		div_slot_t         r;
		logic [HDIV_W:0]   h2;
		logic [CH_W:0]     s2;
		logic              hbit;
		logic              sbit;
		r    = a;
		h2   = {a.hrem, 1'b0};
		s2   = {a.srem, 1'b0};
		hbit = (h2 >= {1'b0, a.hdiv});
		sbit = (s2 >= {1'b0, a.sdiv});
		r.hrem = hbit ? HDIV_W'(h2 - {1'b0, a.hdiv}) : h2[HDIV_W-1:0];
		r.srem = sbit ? CH_W'(s2 - {1'b0, a.sdiv}) : s2[CH_W-1:0];
		r.hquo = {a.hquo[FRAC_W-2:0], hbit};
		r.squo = {a.squo[FRAC_W-2:0], sbit};
		return r;
	endfunction

	// Advance the whole pipe unless a result is held at the output.
	logic adv;
	assign adv         = !hsl_valid || hsl_ready;
	assign pixel_ready = adv;

	// ---------------- stage 1: max, min and hue offset difference ----------
	logic v_s1;
	ext_t ext_s1;
	ext_t ext_d;

	always_comb begin
		ext_d = '0;
		if (pixel.red >= pixel.green && pixel.red >= pixel.blue) begin
			ext_d.sel  = SEL_RED;
			ext_d.hi   = pixel.red;
			ext_d.lo   = (pixel.green < pixel.blue) ? pixel.green : pixel.blue;
			ext_d.diff = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
		end else if (pixel.green >= pixel.blue) begin
			ext_d.sel  = SEL_GREEN;
			ext_d.hi   = pixel.green;
			ext_d.lo   = (pixel.red < pixel.blue) ? pixel.red : pixel.blue;
			ext_d.diff = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
		end else begin
			ext_d.sel  = SEL_BLUE;
			ext_d.hi   = pixel.blue;
			ext_d.lo   = (pixel.red < pixel.green) ? pixel.red : pixel.green;
			ext_d.diff = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
		end
	end

	// ---------------- stage 2: sum, spread, divisors, hue dividend ---------
	logic      v_s2;
	div_slot_t init_s2;
	div_slot_t init_d;

	logic [CH_W-1:0]   spread;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]  den;
	logic [HDIV_W-1:0] six_d;
	logic [HDIV_W-1:0] base;
	logic [HDIV_W:0]   t_ext;

	always_comb begin
		spread = ext_s1.hi - ext_s1.lo;
		sum    = {1'b0, ext_s1.hi} + {1'b0, ext_s1.lo};
		// Light pixels use the distance to white as the saturation divisor.
		den    = (sum > SUM_W'(255)) ? SUM_W'(SUM_W'(510) - sum) : sum;
		six_d  = HDIV_W'({spread, 2'b00}) + HDIV_W'({spread, 1'b0});
		case (ext_s1.sel)
			SEL_RED:   base = ext_s1.diff[DIFF_W-1] ? six_d : '0;
			SEL_GREEN: base = HDIV_W'({spread, 1'b0});
			SEL_BLUE:  base = HDIV_W'({spread, 2'b00});
			default:   base = '0;
		endcase
		t_ext = {1'b0, base} + {{(HDIV_W+1-DIFF_W){ext_s1.diff[DIFF_W-1]}}, ext_s1.diff};

		init_d          = '0;
		init_d.hrem     = t_ext[HDIV_W-1:0];
		init_d.hdiv     = six_d;
		init_d.sdiv     = den[CH_W-1:0];
		// Spread equal to the divisor means a ratio of one: saturate.
		init_d.sat_full = ({1'b0, spread} == den);
		init_d.srem     = init_d.sat_full ? '0 : spread;
		init_d.achro    = (spread == '0);
		init_d.lsum     = sum;
	end

	// ---------------- stages 3..18: one quotient bit per stage -------------
	// Element k of the arrays is pipeline stage 3 + k.
	logic      v_div_s3   [FRAC_W];
	div_slot_t div_s3     [FRAC_W];

	genvar k;
	for (k = 0; k < FRAC_W; k++) begin : g_div
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_div_s3[k] <= 1'b0;
				end else if (adv) begin
					v_div_s3[k] <= v_s2;
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					div_s3[k] <= div_step(init_s2);
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_div_s3[k] <= 1'b0;
				end else if (adv) begin
					v_div_s3[k] <= v_div_s3[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					div_s3[k] <= div_step(div_s3[k-1]);
				end
			end
		end
	end

	// ---------------- output register --------------------------------------
	hsl_t      out_d;
	div_slot_t last;

	always_comb begin
		last                = div_s3[FRAC_W-1];
		out_d.lightness_sum = last.lsum;
		out_d.achromatic    = last.achro;
		if (last.achro) begin
			out_d.hue        = '0;
			out_d.saturation = '0;
		end else begin
			out_d.hue        = last.hquo;
			out_d.saturation = last.sat_full ? SAT_MAX : last.squo;
		end
	end

	// Valid bits: advance with the pipe, hold on stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			hsl_valid <= 1'b0;
		end else if (adv) begin
			v_s1      <= pixel_valid;
			v_s2      <= v_s1;
			hsl_valid <= v_div_s3[FRAC_W-1];
		end
	end

	// Payload: no reset, hold on stall.
	always_ff @(posedge clk) begin
		if (adv) begin
			ext_s1  <= ext_d;
			init_s2 <= init_d;
			hsl     <= out_d;
		end
	end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rgbhsl_pkg::*;

	localparam int RANDOM_PIXELS = 1950;
	localparam int DRAIN_CYCLES  = 40;      // a margin beyond the pipeline depth
	localparam int CYCLE_LIMIT   = 200000;  // far above the slowest legal run
	localparam int MAX_REPORTS   = 10;

	// One pixel in flight: keep the request beside its predicted result so
	// that an error report can show what went in.
	typedef struct {
		pixel_t px;
		hsl_t   hsl;
	} hsl_expectation_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   pixel_valid = 1'b0;
	logic   pixel_ready;
	pixel_t pixel = '0;
	logic   hsl_valid;
	logic   hsl_ready = 1'b0;
	hsl_t   hsl;

	pixel_t           pending_pixels[$];
	hsl_expectation_t expected_hsl[$];
	int               total_pixels = 0;
	int               accepted_count = 0;
	int               mismatch_count = 0;
	int               cycle_count = 0;

	rgb_to_hsl_converter_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.hsl_valid   (hsl_valid),
		.hsl_ready   (hsl_ready),
		.hsl         (hsl)
	);

	always #5 clk = ~clk;

	// Predict one result. Lightness is the exact max + min; hue and saturation
	// are floored quotients in Q0.16, with the saturation capped at all ones.
	function automatic hsl_t compute_hsl(pixel_t px);
		logic [CH_W-1:0]   hi;
		logic [CH_W-1:0]   lo;
		logic [CH_W-1:0]   spread;
		logic [SUM_W-1:0]  sum;
		logic [SUM_W-1:0]  sat_den;
		logic [23:0]       sat_quo;
		logic [HDIV_W-1:0] hue_den;
		logic [HDIV_W-1:0] turn;
		logic [26:0]       hue_quo;
		hsl_t              res;
		hi = px.red;
		if (px.green > hi) hi = px.green;
		if (px.blue > hi) hi = px.blue;
		lo = px.red;
		if (px.green < lo) lo = px.green;
		if (px.blue < lo) lo = px.blue;
		sum = SUM_W'(hi) + SUM_W'(lo);
		spread = hi - lo;
		res = '0;
		res.lightness_sum = sum;
		if (spread == '0) begin
			res.achromatic = 1'b1;
		end else begin
			// Mirror the divisor around the midpoint for bright pixels.
			sat_den = (sum > SUM_W'(255)) ? SUM_W'(510) - sum : sum;
			if (sat_den == '0) begin
				res.saturation = SAT_MAX;
			end else begin
				sat_quo = {spread, 16'h0000} / 24'(sat_den);
				res.saturation = (sat_quo > 24'(SAT_MAX)) ? SAT_MAX : sat_quo[FRAC_W-1:0];
			end
			// Place the hue on a 6*spread scale; red takes ties, then green.
			hue_den = HDIV_W'(6) * HDIV_W'(spread);
			if (px.red == hi) begin
				if (px.green >= px.blue)
					turn = HDIV_W'(px.green - px.blue);
				else
					turn = hue_den - HDIV_W'(px.blue - px.green);
			end else if (px.green == hi) begin
				turn = HDIV_W'(2) * HDIV_W'(spread) + HDIV_W'(px.blue) - HDIV_W'(px.red);
			end else begin
				turn = HDIV_W'(4) * HDIV_W'(spread) + HDIV_W'(px.red) - HDIV_W'(px.green);
			end
			hue_quo = {turn, 16'h0000} / 27'(hue_den);
			res.hue = hue_quo[FRAC_W-1:0];
		end
		return res;
	endfunction

	// Idle rates by phase of the run: a slow receiver first, then a slow
	// sender, then both at full speed.
	function automatic int sender_idle_pct();
		if (accepted_count < total_pixels / 3) return 35;
		if (accepted_count < 2 * total_pixels / 3) return 66;
		return 0;
	endfunction

	function automatic int receiver_stall_pct();
		if (accepted_count < total_pixels / 3) return 66;
		if (accepted_count < 2 * total_pixels / 3) return 35;
		return 0;
	endfunction

	task automatic queue_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b);
		pixel_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		pending_pixels.push_back(px);
	endtask

	// Pixel driver: record each accepted request, then present the next one
	// or drop valid for an idle cycle. Hold the payload while it waits.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			pixel <= '0;
		end else begin
			if (pixel_valid && pixel_ready) begin
				hsl_expectation_t exp_item;
				exp_item.px = pixel;
				exp_item.hsl = compute_hsl(pixel);
				expected_hsl.push_back(exp_item);
				accepted_count <= accepted_count + 1;
			end
			if (!pixel_valid || pixel_ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
					pixel_valid <= 1'b1;
					pixel <= pending_pixels.pop_front();
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each accepted result against the oldest
	// prediction, field by field, and stall the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsl_ready <= 1'b0;
		end else begin
			if (hsl_valid && hsl_ready) begin
				if (expected_hsl.size() == 0) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= MAX_REPORTS)
						$display("hsl result with no pixel pending: hue %0d sat %0d sum %0d achro %0b",
							hsl.hue, hsl.saturation, hsl.lightness_sum, hsl.achromatic);
				end else begin
					hsl_expectation_t exp_item;
					exp_item = expected_hsl.pop_front();
					if (hsl.hue !== exp_item.hsl.hue ||
						hsl.saturation !== exp_item.hsl.saturation ||
						hsl.lightness_sum !== exp_item.hsl.lightness_sum ||
						hsl.achromatic !== exp_item.hsl.achromatic) begin
						mismatch_count = mismatch_count + 1;
						if (mismatch_count <= MAX_REPORTS)
							$display("hsl result error for rgb (%0d,%0d,%0d): %s %0d %0d %0d %0b, %s %0d %0d %0d %0b",
								exp_item.px.red, exp_item.px.green, exp_item.px.blue,
								"expected", exp_item.hsl.hue, exp_item.hsl.saturation,
								exp_item.hsl.lightness_sum, exp_item.hsl.achromatic,
								"got", hsl.hue, hsl.saturation, hsl.lightness_sum, hsl.achromatic);
					end
				end
			end
			hsl_ready <= ($urandom_range(99) >= receiver_stall_pct());
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rgb_to_hsl_converter_unit: mismatch");
			$finish;
		end
	end

	initial begin
		int kind;
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;

		// Directed pixels: black, white and gray, the primaries, every tie
		// for the maximum, each channel as the max, the hue wrap when green
		// sits below blue, the lightness midpoint and the saturated cases.
		queue_pixel(8'd0, 8'd0, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd255);
		queue_pixel(8'd128, 8'd128, 8'd128);
		queue_pixel(8'd255, 8'd0, 8'd0);
		queue_pixel(8'd0, 8'd255, 8'd0);
		queue_pixel(8'd0, 8'd0, 8'd255);
		queue_pixel(8'd255, 8'd0, 8'd255);
		queue_pixel(8'd255, 8'd255, 8'd0);
		queue_pixel(8'd0, 8'd255, 8'd255);
		queue_pixel(8'd200, 8'd10, 8'd50);
		queue_pixel(8'd200, 8'd50, 8'd10);
		queue_pixel(8'd10, 8'd200, 8'd50);
		queue_pixel(8'd50, 8'd10, 8'd200);
		queue_pixel(8'd255, 8'd254, 8'd254);
		queue_pixel(8'd1, 8'd0, 8'd0);
		queue_pixel(8'd128, 8'd127, 8'd127);
		queue_pixel(8'd128, 8'd128, 8'd127);
		queue_pixel(8'd129, 8'd127, 8'd127);
		queue_pixel(8'd255, 8'd0, 8'd1);
		queue_pixel(8'd254, 8'd255, 8'd0);
		queue_pixel(8'd1, 8'd1, 8'd0);
		queue_pixel(8'd0, 8'd1, 8'd1);
		queue_pixel(8'd170, 8'd85, 8'd0);

		// Random pixels: mostly uniform, plus ties, grays and corner values.
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			kind = $urandom_range(99);
			r = 8'($urandom_range(255));
			g = 8'($urandom_range(255));
			b = 8'($urandom_range(255));
			if (kind < 15) begin
				case ($urandom_range(2))
					0: g = r;
					1: b = g;
					default: b = r;
				endcase
			end else if (kind < 20) begin
				g = r;
				b = r;
			end else if (kind < 30) begin
				r = ($urandom_range(1) != 0) ? 8'($urandom_range(1)) : 8'(254 + $urandom_range(1));
				g = ($urandom_range(1) != 0) ? 8'($urandom_range(1)) : 8'(254 + $urandom_range(1));
				b = ($urandom_range(1) != 0) ? 8'($urandom_range(1)) : 8'(254 + $urandom_range(1));
			end
			queue_pixel(r, g, b);
		end
		total_pixels = pending_pixels.size();

		// Hold reset, then release it away from the active edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to go in and every result to come out.
		while (pending_pixels.size() != 0 || pixel_valid) @(posedge clk);
		while (expected_hsl.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && expected_hsl.size() == 0) begin
			$display("rgb_to_hsl_converter_unit: match");
		end else begin
			$display("rgb_to_hsl_converter_unit: mismatch");
		end
		$finish;
	end

endmodule
